// ===== rtl/core/set_assoc_cache_tag_sim_core_macros.svh =====
// Assertion macros used by the cache tag simulator checker.
`ifndef SET_ASSOC_CACHE_TAG_SIM_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_SIM_CORE_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define SACTS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SACTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/core/sacts_pkg.sv =====
// Shared types and constants for the cache tag simulator.
package sacts_pkg;

	localparam int ADDR_W       = 32;
	localparam int TAG_W        = 32;
	localparam int TOTAL_W      = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 6;
	localparam int OUT_DATA_W   = 104;
	localparam int OUT_USED_W   = 1 + 3 * TOTAL_W;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;
	localparam int PROD_W       = TOTAL_W + 7;
	localparam int SUM_W        = PROD_W + 1;
	localparam int CYCLES_PER_MISS = 101;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDRESS_BITS = 3'd0,
		CFG_SET_BITS     = 3'd1,
		CFG_WAY_BITS     = 3'd2,
		CFG_BLOCK_BITS   = 3'd3,
		CFG_LRU_MODE     = 3'd4
	} cfg_idx_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic cap;          // capture the request address
		logic split;        // cut address into set and tag
		logic fill_rd;      // read the fill count of the set
		logic used_ld;      // load the clamped fill count
		logic walk_start;   // reset the way pointer for the lookup
		logic walk;         // read the next way
		logic shift_wr;     // write the previously read way one slot down
		logic shift_start;  // point the walk at the first way to move
		logic hit_ld;       // record a hit
		logic commit;       // write tag, fill count, totals
		logic mul;          // scale the miss total
		logic out_ld;       // load the result register
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic match;        // compared way holds the tag
		logic walk_idle;    // nothing left to read or write
		logic room;         // set has a free way
		logic lru;          // replacement order is least recently used
		logic out_free;     // result register can take a new result
	} status_t;

endpackage

// ===== rtl/core/sacts_ram.sv =====
// Generic simple dual port RAM with registered read.
module sacts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sacts_ctrl.sv =====
// Sequencing state machine for one cache lookup and update.
module sacts_ctrl import sacts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SPLIT = 9'b000000010,
		ST_FILL  = 9'b000000100,
		ST_USED  = 9'b000001000,
		ST_SCAN  = 9'b000010000,
		ST_SHIFT = 9'b000100000,
		ST_WRITE = 9'b001000000,
		ST_MUL   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = ST_FILL;
			end
			ST_FILL: begin
				cmd.fill_rd = 1'b1;
				state_d     = ST_USED;
			end
			ST_USED: begin
				cmd.used_ld    = 1'b1;
				cmd.walk_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (st.match) begin
					cmd.hit_ld = 1'b1;
					if (st.lru) begin
						cmd.shift_start = 1'b1;
						state_d         = ST_SHIFT;
					end else begin
						state_d = ST_WRITE;
					end
				end else if (st.walk_idle) begin
					// miss: append if there is room, else evict way 0
					if (st.room) begin
						state_d = ST_WRITE;
					end else begin
						cmd.shift_start = 1'b1;
						state_d         = ST_SHIFT;
					end
				end else begin
					cmd.walk = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (st.walk_idle) begin
					state_d = ST_WRITE;
				end else begin
					cmd.walk     = 1'b1;
					cmd.shift_wr = 1'b1;
				end
			end
			ST_WRITE: begin
				cmd.commit = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/sacts_dp.sv =====
// Datapath: config registers, address split, tag and fill RAMs, totals, result register.
module sacts_dp import sacts_pkg::*; #(
	parameter int MAX_SET_BITS  = 8,
	parameter int MAX_WAYS      = 8,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  logic [ADDR_W-1:0]     in_addr,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << SET_W;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W    = $clog2(MAX_WAYS + 1);
	localparam int TAG_AW   = SET_W + WAY_W;

	localparam logic [6:0] AB_CAP   = 7'(ADDRESS_WIDTH);
	localparam logic [3:0] SB_CAP   = 4'(MAX_SET_BITS);
	localparam logic [4:0] WAYS_CAP = 5'(MAX_WAYS);
	localparam logic [SUM_W-1:0] SAT_SUM = SUM_W'({TOTAL_W{1'b1}});

	// configuration
	logic [5:0] abits_q;
	logic [3:0] sbits_q;
	logic [1:0] wbits_q;
	logic [4:0] bbits_q;
	logic       lru_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abits_q <= 6'd32;
			sbits_q <= '0;
			wbits_q <= '0;
			bbits_q <= '0;
			lru_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_ADDRESS_BITS: abits_q <= cfg_data[5:0];
				CFG_SET_BITS:     sbits_q <= cfg_data[3:0];
				CFG_WAY_BITS:     wbits_q <= cfg_data[1:0];
				CFG_BLOCK_BITS:   bbits_q <= cfg_data[4:0];
				CFG_LRU_MODE:     lru_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [6:0]        ab;
	logic [3:0]        sb;
	logic [4:0]        ways_raw, ways5;
	logic [CNT_W-1:0]  ways;
	logic [ADDR_W-1:0] addr_mask, set_full;
	logic [5:0]        tag_sh;

	assign ab        = (7'(abits_q) > AB_CAP) ? AB_CAP : 7'(abits_q);
	assign addr_mask = (ab >= 7'(ADDR_W)) ? '1 : ~({ADDR_W{1'b1}} << ab);
	assign sb        = (sbits_q > SB_CAP) ? SB_CAP : sbits_q;
	assign ways_raw  = 5'd1 << wbits_q;
	assign ways5     = (ways_raw > WAYS_CAP) ? WAYS_CAP : ways_raw;
	assign ways      = CNT_W'(ways5);

	// address split
	logic [ADDR_W-1:0] addr_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;

	assign set_full = (addr_q >> bbits_q) & ~({ADDR_W{1'b1}} << sb);
	assign tag_sh   = 6'(sb) + 6'(bbits_q);

	always_ff @(posedge clk) begin
		if (cmd.cap)
			addr_q <= in_addr & addr_mask;
		if (cmd.split) begin
			set_q <= set_full[SET_W-1:0];
			tag_q <= TAG_W'(addr_q >> tag_sh);
		end
	end

	// fill counts: RAM plus a valid bit per set so reset reads as zero
	logic [NUM_SETS-1:0] fill_vld_q;
	logic                fill_vld_rd_q;
	logic [CNT_W-1:0]    fill_rdata, fill_eff, used_q, new_used, last_idx;
	logic                room, hit_q;

	assign fill_eff = fill_vld_rd_q ? fill_rdata : '0;
	assign room     = (used_q < ways);
	assign new_used = (!hit_q && room) ? used_q + CNT_W'(1) : used_q;
	assign last_idx = (!hit_q && room) ? used_q : used_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q    <= '0;
			fill_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.fill_rd)
				fill_vld_rd_q <= fill_vld_q[set_q];
			if (cmd.commit)
				fill_vld_q[set_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.used_ld)
			used_q <= (fill_eff > ways) ? ways : fill_eff;
	end

	sacts_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_SETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (set_q),
		.wdata (new_used),
		.re    (cmd.fill_rd),
		.raddr (set_q),
		.rdata (fill_rdata)
	);

	// way walk shared by lookup and shift
	logic [CNT_W-1:0] ptr_q, pidx_q;
	logic             pend_q, walk_go, match;
	logic [TAG_W-1:0] tag_rd;

	assign walk_go = cmd.walk && (ptr_q < used_q);
	assign match   = pend_q && (tag_rd == tag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			pidx_q <= '0;
			pend_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				ptr_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.shift_start) begin
				// LRU hit moves the ways above it, a full miss moves all but way 0
				ptr_q  <= match ? pidx_q + CNT_W'(1) : CNT_W'(1);
				pend_q <= 1'b0;
			end else if (cmd.walk) begin
				pend_q <= walk_go;
				if (walk_go) begin
					ptr_q  <= ptr_q + CNT_W'(1);
					pidx_q <= ptr_q;
				end
			end
			if (cmd.walk_start)
				hit_q <= 1'b0;
			else if (cmd.hit_ld)
				hit_q <= 1'b1;
		end
	end

	logic              shift_we, commit_we, tag_we;
	logic [TAG_AW-1:0] tag_waddr;
	logic [WAY_W-1:0]  shift_way;
	logic [CNT_W-1:0]  shift_dst;

	assign shift_dst = pidx_q - CNT_W'(1);
	assign shift_way = shift_dst[WAY_W-1:0];
	assign shift_we  = cmd.shift_wr && pend_q;
	assign commit_we = cmd.commit && !(hit_q && !lru_q);
	assign tag_we    = shift_we || commit_we;
	assign tag_waddr = shift_we ? {set_q, shift_way} : {set_q, last_idx[WAY_W-1:0]};

	sacts_ram #(
		.WIDTH (TAG_W),
		.DEPTH (1 << TAG_AW)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (shift_we ? tag_rd : tag_q),
		.re    (walk_go),
		.raddr ({set_q, ptr_q[WAY_W-1:0]}),
		.rdata (tag_rd)
	);

	// running totals
	logic [TOTAL_W-1:0] hit_cnt_q, miss_cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   cyc_sum;
	logic [TOTAL_W-1:0] cyc_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (hit_q) begin
				if (hit_cnt_q != '1)
					hit_cnt_q <= hit_cnt_q + TOTAL_W'(1);
			end else begin
				if (miss_cnt_q != '1)
					miss_cnt_q <= miss_cnt_q + TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= PROD_W'(miss_cnt_q) * PROD_W'(CYCLES_PER_MISS);
	end

	assign cyc_sum   = SUM_W'(hit_cnt_q) + SUM_W'(prod_q);
	assign cyc_total = (cyc_sum > SAT_SUM) ? '1 : cyc_sum[TOTAL_W-1:0];

	// result register
	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_ld)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld)
			out_data_q <= {{OUT_PAD_W{1'b0}}, cyc_total, miss_cnt_q, hit_cnt_q, hit_q};
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;

	assign st.match     = match;
	assign st.walk_idle = !pend_q && (ptr_q >= used_q);
	assign st.room      = room;
	assign st.lru       = lru_q;
	assign st.out_free  = !out_vld_q || out_ready;

endmodule

// ===== rtl/core/set_assoc_cache_tag_sim_core.sv =====
// Set-associative cache tag simulator with FIFO or LRU replacement.
// s_tdata carries one access address per request. The block masks it to
// address_bits, splits it into block offset, set index and tag, looks the
// tag up among the filled ways of the set and updates the set. Each
// request gives one result on m_tdata: hit flag and saturating hit, miss
// and cycle totals (hits plus 101 per miss).
// Configuration is written through cfg_we/cfg_idx/cfg_data while idle.
// One request is in flight at a time; the tag RAM is read one way per
// cycle. A new request is taken the cycle after the result is loaded.
// Reset clears totals and fill counts at once (per-set valid bits); no
// clearing pass is needed. A stalled result waits in the output register
// while the next request is processed; the block then holds s_tready
// low until that request's result can be loaded.
module set_assoc_cache_tag_sim_core import sacts_pkg::*; #(
	parameter int MAX_SET_BITS  = 8,
	parameter int MAX_WAYS      = 8,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] access_address
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] hit, [32:1] hit_total, [64:33] miss_total, [96:65] cycle_total, rest zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	sacts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sacts_dp #(
		.MAX_SET_BITS  (MAX_SET_BITS),
		.MAX_WAYS      (MAX_WAYS),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_addr   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

// ===== rtl/core/sacts_checker.sv =====
// Port-level checker for the cache tag simulator, bound to the top level.
`include "set_assoc_cache_tag_sim_core_macros.svh"

module sacts_checker import sacts_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// one request at a time: ready drops right after acceptance
	`SACTS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request accepted while busy")

	`SACTS_ASSERT(a_hit_counted, m_tvalid && m_tdata[0] |-> m_tdata[32:1] != 32'd0, "hit with zero hit total")

	`SACTS_ASSERT(a_miss_counted, m_tvalid && !m_tdata[0] |-> m_tdata[64:33] != 32'd0, "miss with zero miss total")

	`SACTS_ASSERT(a_cycle_bound, m_tvalid |-> m_tdata[96:65] >= m_tdata[32:1], "cycle total below hit total")

	`SACTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind set_assoc_cache_tag_sim_core sacts_checker u_checker (.*);

// ===== sim/tb_set_assoc_cache_tag_sim_core.sv =====
// Self-checking testbench for the set-associative cache tag simulator core.
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_sim_core;
	import sacts_pkg::*;

	localparam int SET_CAP       = 8;
	localparam int WAY_CAP       = 8;
	localparam int ADDR_CAP      = 32;
	localparam int NUM_SETS      = 1 << SET_CAP;
	localparam int RAND_PHASES   = 16;
	localparam int PHASE_ITEMS   = 78;
	localparam int SETTLE_CYCLES = 60;
	localparam int PRINT_CAP     = 40;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam longint unsigned SAT = 64'hFFFF_FFFF;

	typedef struct packed {
		logic        hit;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] cycles;
	} lookup_result_t;

	typedef struct packed {
		logic           is_geom;
		logic [5:0]     ab;
		logic [3:0]     sb;
		logic [1:0]     wb;
		logic [4:0]     bb;
		logic           lru;
		logic [31:0]    addr;
		logic           known;
		lookup_result_t want;
	} stim_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [ADDR_W-1:0]     s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_ADDRESS_BITS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// tag store mirror and geometry
	logic [31:0]     tag_mem [NUM_SETS][WAY_CAP];
	int unsigned     fill_mem [NUM_SETS];
	longint unsigned hit_count = 0;
	longint unsigned miss_count = 0;
	logic [5:0]      geo_addr_bits = 6'd32;
	logic [3:0]      geo_set_bits = '0;
	logic [1:0]      geo_way_bits = '0;
	logic [4:0]      geo_block_bits = '0;
	logic            geo_lru = 1'b0;

	lookup_result_t  results_due [$];
	int unsigned     fail_count = 0;
	int unsigned     result_index = 0;
	int unsigned     cycle_count = 0;
	int unsigned     send_idle_pct = 0;
	int unsigned     sink_stall_pct = 0;

	set_assoc_cache_tag_sim_core #(
		.MAX_SET_BITS (SET_CAP),
		.MAX_WAYS     (WAY_CAP),
		.ADDRESS_WIDTH(ADDR_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // [31:0] access_address
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // [0] hit, [32:1] hits, [64:33] misses, [96:65] cycles
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic lookup_result_t lookup_and_update(input logic [31:0] raw);
		int unsigned     eff_ab, eff_sb, ways, set_idx, used, j, k;
		logic [63:0]     addr, tag;
		bit              found;
		longint unsigned cyc;
		lookup_result_t  r;
		eff_ab = (geo_addr_bits > ADDR_CAP) ? ADDR_CAP : geo_addr_bits;
		eff_sb = (geo_set_bits > SET_CAP) ? SET_CAP : geo_set_bits;
		ways = 1 << geo_way_bits;
		if (ways > WAY_CAP) begin
			ways = WAY_CAP;
		end
		addr = {32'd0, raw} & ((64'd1 << eff_ab) - 64'd1);
		set_idx = 32'(((addr >> geo_block_bits) & ((64'd1 << eff_sb) - 64'd1))
			& (NUM_SETS - 1));
		tag = addr >> (eff_sb + geo_block_bits);
		// an overfull set (ways shrank) counts as full
		used = (fill_mem[set_idx] > ways) ? ways : fill_mem[set_idx];
		found = 1'b0;
		for (j = 0; j < used; j++) begin
			if (tag_mem[set_idx][j] == tag[31:0]) begin
				found = 1'b1;
				break;
			end
		end
		if (found) begin
			if (geo_lru) begin
				for (k = j + 1; k < used; k++) begin
					tag_mem[set_idx][k - 1] = tag_mem[set_idx][k];
				end
				tag_mem[set_idx][used - 1] = tag[31:0];
			end
			if (hit_count < SAT) begin
				hit_count++;
			end
		end else begin
			if (used < ways) begin
				tag_mem[set_idx][used] = tag[31:0];
				used++;
			end else begin
				for (k = 1; k < used; k++) begin
					tag_mem[set_idx][k - 1] = tag_mem[set_idx][k];
				end
				tag_mem[set_idx][used - 1] = tag[31:0];
			end
			if (miss_count < SAT) begin
				miss_count++;
			end
		end
		fill_mem[set_idx] = used;
		cyc = hit_count + CYCLES_PER_MISS * miss_count;
		if (cyc > SAT) begin
			cyc = SAT;
		end
		r.hit = found;
		r.hits = hit_count[31:0];
		r.misses = miss_count[31:0];
		r.cycles = cyc[31:0];
		return r;
	endfunction

	function automatic stim_row_t geom_row(input logic [5:0] ab, input logic [3:0] sb,
			input logic [1:0] wb, input logic [4:0] bb, input logic lru);
		stim_row_t r;
		r = '0;
		r.is_geom = 1'b1;
		r.ab = ab;
		r.sb = sb;
		r.wb = wb;
		r.bb = bb;
		r.lru = lru;
		return r;
	endfunction

	function automatic stim_row_t access_row(input logic [31:0] a);
		stim_row_t r;
		r = '0;
		r.addr = a;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [31:0] a, input logic h,
			input int unsigned hits, input int unsigned misses);
		stim_row_t r;
		r = access_row(a);
		r.known = 1'b1;
		r.want.hit = h;
		r.want.hits = hits;
		r.want.misses = misses;
		r.want.cycles = hits + CYCLES_PER_MISS * misses;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		fail_count++;
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] w);
		lookup_result_t want;
		result_index++;
		if (results_due.size() == 0) begin
			report_mismatch($sformatf("result %0d with no request pending", result_index));
			return;
		end
		want = results_due.pop_front();
		if (w[0] !== want.hit) begin
			report_mismatch($sformatf("result %0d hit: got %0b, want %0b",
				result_index, w[0], want.hit));
		end
		if (w[32:1] !== want.hits) begin
			report_mismatch($sformatf("result %0d hit_total: got %0d, want %0d",
				result_index, w[32:1], want.hits));
		end
		if (w[64:33] !== want.misses) begin
			report_mismatch($sformatf("result %0d miss_total: got %0d, want %0d",
				result_index, w[64:33], want.misses));
		end
		if (w[96:65] !== want.cycles) begin
			report_mismatch($sformatf("result %0d cycle_total: got %0d, want %0d",
				result_index, w[96:65], want.cycles));
		end
		if (w[OUT_DATA_W-1:OUT_USED_W] !== '0) begin
			report_mismatch($sformatf("result %0d pad bits not zero: %h",
				result_index, w[OUT_DATA_W-1:OUT_USED_W]));
		end
	endtask

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send_access(input logic [31:0] a, input logic known,
			input lookup_result_t want);
		lookup_result_t predicted;
		while ($urandom_range(1, 100) <= send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predicted = lookup_and_update(a);
		results_due.push_back(known ? want : predicted);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [5:0] ab, input logic [3:0] sb,
			input logic [1:0] wb, input logic [4:0] bb, input logic lru);
		write_reg(CFG_ADDRESS_BITS, ab);
		write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
		write_reg(CFG_WAY_BITS, CFG_DATA_W'(wb));
		write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(bb));
		write_reg(CFG_LRU_MODE, CFG_DATA_W'(lru));
		cfg_we <= 1'b0;
		geo_addr_bits = ab;
		geo_set_bits = sb;
		geo_way_bits = wb;
		geo_block_bits = bb;
		geo_lru = lru;
	endtask

	initial begin : result_sink
		logic                  took;
		logic [OUT_DATA_W-1:0] word;
		forever begin
			@(negedge clk);
			took = arst_n && m_tvalid && m_tready;
			word = m_tdata;
			@(posedge clk);
			if (took) begin
				check_result(word);
			end
			m_tready <= ($urandom_range(1, 100) > sink_stall_pct);
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		stim_row_t      rows [$];
		lookup_result_t none;
		logic [31:0]    pool [24];
		logic [63:0]    set_mask, offs_mask;
		logic [31:0]    common, a;
		int unsigned    pool_n, eff_sb;
		logic [5:0]     ab;
		logic [3:0]     sb;
		logic [1:0]     wb;
		logic [4:0]     bb;

		none = '0;
		foreach (tag_mem[s, w]) begin
			tag_mem[s][w] = '0;
		end
		foreach (fill_mem[s]) begin
			fill_mem[s] = 0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: one set, one way, the whole address is the tag
		rows.push_back(known_row(32'h0000_0000, 1'b0, 0, 1));
		rows.push_back(known_row(32'h0000_0000, 1'b1, 1, 1));
		rows.push_back(known_row(32'hFFFF_FFFF, 1'b0, 1, 2));
		rows.push_back(known_row(32'hFFFF_FFFF, 1'b1, 2, 2));
		rows.push_back(known_row(32'h0000_0000, 1'b0, 2, 3));
		// zero address width folds everything onto tag 0; set bits above the cap
		rows.push_back(geom_row(6'd0, 4'd15, 2'd3, 5'd31, 1'b1));
		rows.push_back(known_row(32'hFFFF_FFFF, 1'b1, 3, 3));
		rows.push_back(known_row(32'h1234_5678, 1'b1, 4, 3));
		// oversize width clamps to 32; set sits on bit 31, tag shifted out
		rows.push_back(geom_row(6'd63, 4'd8, 2'd3, 5'd31, 1'b1));
		rows.push_back(known_row(32'h8000_0000, 1'b0, 4, 4));
		rows.push_back(known_row(32'h7FFF_FFFF, 1'b1, 5, 4));
		// four-way FIFO: fill, hit, evict oldest
		rows.push_back(geom_row(6'd32, 4'd2, 2'd2, 5'd4, 1'b0));
		rows.push_back(access_row(32'h0000_0040));
		rows.push_back(access_row(32'h0000_0080));
		rows.push_back(access_row(32'h0000_00C0));
		rows.push_back(access_row(32'h0000_0000));
		rows.push_back(access_row(32'h0000_0100));
		rows.push_back(access_row(32'h0000_0000));
		// same sets under LRU: hit reorders, then evictions
		rows.push_back(geom_row(6'd32, 4'd2, 2'd2, 5'd4, 1'b1));
		rows.push_back(access_row(32'h0000_0080));
		rows.push_back(access_row(32'h0000_0140));
		rows.push_back(access_row(32'h0000_00C0));
		// shrink to one way while set 0 holds four lines
		rows.push_back(geom_row(6'd32, 4'd2, 2'd0, 5'd4, 1'b1));
		rows.push_back(access_row(32'h0000_0100));
		rows.push_back(access_row(32'h0000_0100));
		// narrow address: high bits dropped
		rows.push_back(geom_row(6'd5, 4'd1, 2'd1, 5'd0, 1'b0));
		rows.push_back(access_row(32'hFFFF_FFE1));
		rows.push_back(access_row(32'h0000_001F));
		rows.push_back(access_row(32'h0000_0021));

		foreach (rows[i]) begin
			if (rows[i].is_geom) begin
				wait_idle();
				set_geometry(rows[i].ab, rows[i].sb, rows[i].wb, rows[i].bb, rows[i].lru);
			end else begin
				send_access(rows[i].addr, rows[i].known, rows[i].want);
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			ab = ($urandom_range(0, 99) < 15) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(20, 32));
			sb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(0, 6));
			wb = 2'($urandom_range(0, 3));
			bb = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 6));
			set_geometry(ab, sb, wb, bb, 1'($urandom_range(0, 1)));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					sink_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					sink_stall_pct = 50;
				end
				default: begin
					send_idle_pct = 25;
					sink_stall_pct = 25;
				end
			endcase

			// small working set, each entry forced into one common set with even odds to drive evictions
			eff_sb = (sb > SET_CAP) ? SET_CAP : sb;
			set_mask = ((64'd1 << eff_sb) - 64'd1) << bb;
			offs_mask = (64'd1 << bb) - 64'd1;
			pool_n = $urandom_range(2, 24);
			common = $urandom;
			for (int i = 0; i < pool_n; i++) begin
				pool[i] = $urandom;
				if ($urandom_range(0, 1) == 1) begin
					pool[i] = (pool[i] & ~set_mask[31:0]) | (common & set_mask[31:0]);
				end
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					a = pool[$urandom_range(0, pool_n - 1)] ^ ($urandom & offs_mask[31:0]);
				end else begin
					a = $urandom;
				end
				send_access(a, 1'b0, none);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
